### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the barometric compensation block.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) `ASSERT_ALWAYS(lbl, clk, rst, !(cond))
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

### rtl/core/bsc_pkg.sv
// Shared types, constants and helper functions of the barometric compensation block.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package bsc_pkg;

   // One queued sensor word.
   typedef struct packed {
      logic [18:0] up;
      logic [15:0] ut;
   } item_type;

   // Calibration coefficients as held in the CSRs (signedness applied at use).
   typedef struct packed {
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] ac5;
      logic [15:0] ac6;
      logic [15:0] b1;
      logic [15:0] b2;
      logic [15:0] mc;
      logic [15:0] md;
      logic [1:0]  oss;
   } cal_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quo;
   } div_rsp_type;

   // CSR indexes.
   typedef enum logic [1:0] {
      CSR_AC1_AC4 = 2'd0,
      CSR_AC5_B2  = 2'd1,
      CSR_MC_MD   = 2'd2,
      CSR_OSS     = 2'd3
   } csr_index_type;

   // Scaling constants of the compensation scheme.
   localparam logic signed [63:0] B6Offset    = 64'sd4000;
   localparam logic signed [63:0] X3Bias      = 64'sd32768;
   localparam logic [15:0]        B7Scale     = 16'd50000;
   localparam logic signed [63:0] PSqScale    = 64'sd3038;
   localparam logic signed [15:0] PLinScale   = -16'sd7357;
   localparam logic signed [63:0] POffset     = 64'sd3791;
   localparam logic signed [63:0] PressureMax = 64'sd1048575;
   localparam logic signed [63:0] TempMax     = 64'sd32767;
   localparam logic signed [63:0] TempMin     = -64'sd32768;

   // Divide by 2^s, rounding toward zero.
   function automatic logic signed [63:0] tdiv(input logic signed [63:0] v,
                                               input int unsigned s);
      logic [63:0] mag;
      mag = v[63] ? 64'(-v) : 64'(v);
      mag = mag >> s;
      return v[63] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage
`default_nettype wire

### rtl/core/bsc_front.sv
// Front end: accepts request words and holds them in a short queue for the back end.
// Depends on bsc_pkg.
`default_nettype none
module bsc_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [39:0]        req_tdata,
   output logic                    q_valid,
   output bsc_pkg::item_type       q_item,
   input  wire logic               q_pop
);
   localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   bsc_pkg::item_type     mem_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  push;
   bsc_pkg::item_type     item_w;

   // Split the word into its fields.
   assign item_w.ut = req_tdata[15:0];
   assign item_w.up = req_tdata[34:16];

   assign req_tready = (count_ff != CntWidth'(QUEUE_DEPTH));
   assign push       = req_tvalid & req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_w;
      end
   end
endmodule
`default_nettype wire

### rtl/core/bsc_mul.sv
// Digit-serial 64-bit multiplier, product modulo 2^64, 16 bits of b per cycle.
// Depends on bsc_pkg.
`default_nettype none
module bsc_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bsc_pkg::mul_req_type req,
   output bsc_pkg::mul_rsp_type     rsp
);
   localparam int DigitWidth = 16;
   localparam int Digits     = 64 / DigitWidth;
   localparam int CntWidth   = $clog2(Digits);

   logic [63:0]         a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;

   // One partial product per cycle, added at the running weight.
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + 64'(a_ff * 64'(b_ff[DigitWidth-1:0]));
         a_in   = a_ff << DigitWidth;
         b_in   = b_ff >> DigitWidth;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(Digits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;
endmodule
`default_nettype wire

### rtl/core/bsc_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Depends on bsc_pkg.
`default_nettype none
module bsc_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bsc_pkg::div_req_type req,
   output bsc_pkg::div_rsp_type     rsp
);
   logic [31:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [32:0] rem_sh;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   assign rem_sh = {rem_ff, quo_ff[31]};

   // Shift in one numerator bit and subtract when the divisor fits.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = 32'(rem_sh - {1'b0, den_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
endmodule
`default_nettype wire

### rtl/core/bsc_back.sv
// Back end: sequencer that runs the temperature and pressure compensation for one word
// on the shared multiplier and divider, and holds the result register. Depends on bsc_pkg.
`default_nettype none
module bsc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bsc_pkg::cal_type     cal,
   input  wire logic                 q_valid,
   input  wire bsc_pkg::item_type    q_item,
   output logic                      q_pop,
   output bsc_pkg::mul_req_type      mul_req,
   input  wire bsc_pkg::mul_rsp_type mul_rsp,
   output bsc_pkg::div_req_type      div_req,
   input  wire bsc_pkg::div_rsp_type div_rsp,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [39:0]               rsp_tdata,
   output logic                      rsp_tuser
);
   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_TEMP  = 13'b0000000000010,
      ST_TDIV  = 13'b0000000000100,
      ST_SQ    = 13'b0000000001000,
      ST_M1    = 13'b0000000010000,
      ST_M2    = 13'b0000000100000,
      ST_B4    = 13'b0000001000000,
      ST_B7    = 13'b0000010000000,
      ST_PDIV  = 13'b0000100000000,
      ST_PSQ   = 13'b0001000000000,
      ST_PMUL  = 13'b0010000000000,
      ST_DONE  = 13'b0100000000000,
      ST_SPARE = 13'b1000000000000
   } state_type;

   state_type                state_ff, state_in;
   bsc_pkg::item_type        item_ff, item_in;
   logic signed [63:0]       x1_ff, x1_in, sq_ff, sq_in, b3_ff, b3_in, x3_ff, x3_in;
   logic signed [63:0]       pf_ff, pf_in;
   logic signed [31:0]       b6_ff, b6_in, p_ff, p_in;
   logic signed [15:0]       t_ff, t_in;
   logic [31:0]              b4_ff, b4_in, b7_ff, b7_in;
   logic                     neg_ff, neg_in, dbl_ff, dbl_in, err_ff, err_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [15:0]              rsp_temp_ff, rsp_temp_in;
   logic [19:0]              rsp_pres_ff, rsp_pres_in;
   logic                     rsp_err_ff, rsp_err_in;

   // Datapath terms, one group per sequencer step.
   logic signed [17:0]       diff_w;
   logic signed [34:0]       tprod_w;
   logic signed [63:0]       den_w, quo64_w, x2t_w, b5_w, tv_w, prod_w, sqv_w;
   logic signed [31:0]       mcn32_w, b6v_w, pv_w;
   logic [31:0]              mc_abs_w, den_abs_w, x3b_w, b4v_w, b7v_w, qv_w;
   logic signed [47:0]       ac2b6_w, ac3b6_w, lin_w;
   logic signed [63:0]       x3v_w, b3s_w, b3v_w, x3p2_w, pd8_w, pf_w;
   logic [15:0]              tsat_w;
   logic [19:0]              psat_w;

   // Temperature: X1 from the raw word, then the signed divide for X2.
   assign diff_w    = $signed({2'b00, q_item.ut}) - $signed({2'b00, cal.ac6});
   assign tprod_w   = diff_w * $signed({1'b0, cal.ac5});
   assign den_w     = x1_ff + 64'($signed(cal.md));
   assign mcn32_w   = 32'($signed({cal.mc, 11'b0}));
   assign mc_abs_w  = mcn32_w[31] ? 32'(-mcn32_w) : 32'(mcn32_w);
   assign den_abs_w = den_w[63] ? 32'(-den_w) : 32'(den_w);
   assign quo64_w   = $signed({32'b0, div_rsp.quo});
   assign x2t_w     = neg_ff ? -quo64_w : quo64_w;
   assign b5_w      = x1_ff + x2t_w;
   assign tv_w      = bsc_pkg::tdiv(b5_w + 64'sd8, 4);
   assign b6v_w     = 32'(b5_w - bsc_pkg::B6Offset);

   // Pressure: B3, B4 and B7 terms.
   assign prod_w  = $signed(mul_rsp.prod);
   assign sqv_w   = bsc_pkg::tdiv(prod_w, 12);
   assign ac2b6_w = 48'($signed(cal.ac2)) * 48'(b6_ff);
   assign ac3b6_w = 48'($signed(cal.ac3)) * 48'(b6_ff);
   assign x3v_w   = bsc_pkg::tdiv(prod_w, 11) + bsc_pkg::tdiv(64'(ac2b6_w), 11);
   assign b3s_w   = (64'($signed(cal.ac1)) <<< 2) + x3v_w;
   assign b3v_w   = bsc_pkg::tdiv((b3s_w <<< cal.oss) + 64'sd2, 2);
   assign x3p2_w  = bsc_pkg::tdiv(bsc_pkg::tdiv(64'(ac3b6_w), 13)
                                  + bsc_pkg::tdiv(prod_w, 16) + 64'sd2, 2);
   assign x3b_w   = 32'(x3_ff + bsc_pkg::X3Bias);
   assign b4v_w   = 32'(32'(cal.ac4) * x3b_w) >> 15;
   assign b7v_w   = 32'((32'(item_ff.up) - b3_ff[31:0])
                        * 32'(bsc_pkg::B7Scale >> cal.oss));

   // Pressure: quotient and the final correction.
   assign qv_w  = dbl_ff ? {div_rsp.quo[30:0], 1'b0} : div_rsp.quo;
   assign pv_w  = $signed(qv_w);
   assign pd8_w = bsc_pkg::tdiv(64'(pv_w), 8);
   assign lin_w = 48'(bsc_pkg::PLinScale) * 48'(p_ff);
   assign pf_w  = 64'(p_ff) + bsc_pkg::tdiv(bsc_pkg::tdiv(prod_w, 16)
                  + bsc_pkg::tdiv(64'(lin_w), 16) + bsc_pkg::POffset, 4);

   // Saturation of both results.
   assign tsat_w = (tv_w > bsc_pkg::TempMax) ? 16'h7fff :
                   (tv_w < bsc_pkg::TempMin) ? 16'h8000 : tv_w[15:0];
   assign psat_w = pf_ff[63] ? 20'd0 :
                   (pf_ff > bsc_pkg::PressureMax) ? 20'hfffff : pf_ff[19:0];

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      x1_in        = x1_ff;
      neg_in       = neg_ff;
      b6_in        = b6_ff;
      t_in         = t_ff;
      sq_in        = sq_ff;
      b3_in        = b3_ff;
      x3_in        = x3_ff;
      b4_in        = b4_ff;
      b7_in        = b7_ff;
      dbl_in       = dbl_ff;
      p_in         = p_ff;
      pf_in        = pf_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_temp_in  = rsp_temp_ff;
      rsp_pres_in  = rsp_pres_ff;
      rsp_err_in   = rsp_err_ff;
      q_pop        = 1'b0;
      mul_req      = '0;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               x1_in    = bsc_pkg::tdiv(64'(tprod_w), 15);
               err_in   = 1'b0;
               state_in = ST_TEMP;
            end
         end
         ST_TEMP: begin
            if (den_w == '0) begin
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = mc_abs_w;
               div_req.den   = den_abs_w;
               neg_in        = mcn32_w[31] ^ den_w[63];
               state_in      = ST_TDIV;
            end
         end
         ST_TDIV: begin
            if (div_rsp.done) begin
               b6_in         = b6v_w;
               t_in          = $signed(tsat_w);
               mul_req.start = 1'b1;
               mul_req.a     = 64'(b6v_w);
               mul_req.b     = 64'(b6v_w);
               state_in      = ST_SQ;
            end
         end
         ST_SQ: begin
            if (mul_rsp.done) begin
               sq_in         = sqv_w;
               mul_req.start = 1'b1;
               mul_req.a     = 64'($signed(cal.b2));
               mul_req.b     = sqv_w;
               state_in      = ST_M1;
            end
         end
         ST_M1: begin
            if (mul_rsp.done) begin
               b3_in         = b3v_w;
               mul_req.start = 1'b1;
               mul_req.a     = 64'($signed(cal.b1));
               mul_req.b     = sq_ff;
               state_in      = ST_M2;
            end
         end
         ST_M2: begin
            if (mul_rsp.done) begin
               x3_in    = x3p2_w;
               state_in = ST_B4;
            end
         end
         ST_B4: begin
            b4_in    = b4v_w;
            b7_in    = b7v_w;
            state_in = ST_B7;
         end
         ST_B7: begin
            if (b4_ff == '0) begin
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               // Keep the doubled dividend inside 32 bits; double the quotient instead.
               div_req.start = 1'b1;
               div_req.den   = b4_ff;
               div_req.num   = b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
               dbl_in        = b7_ff[31];
               state_in      = ST_PDIV;
            end
         end
         ST_PDIV: begin
            if (div_rsp.done) begin
               p_in          = pv_w;
               mul_req.start = 1'b1;
               mul_req.a     = pd8_w;
               mul_req.b     = pd8_w;
               state_in      = ST_PSQ;
            end
         end
         ST_PSQ: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = mul_rsp.prod;
               mul_req.b     = bsc_pkg::PSqScale;
               state_in      = ST_PMUL;
            end
         end
         ST_PMUL: begin
            if (mul_rsp.done) begin
               pf_in    = pf_w;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = err_ff ? 16'd0 : t_ff;
               rsp_pres_in  = err_ff ? 20'd0 : psat_w;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      x1_ff       <= x1_in;
      neg_ff      <= neg_in;
      b6_ff       <= b6_in;
      t_ff        <= t_in;
      sq_ff       <= sq_in;
      b3_ff       <= b3_in;
      x3_ff       <= x3_in;
      b4_ff       <= b4_in;
      b7_ff       <= b7_in;
      dbl_ff      <= dbl_in;
      p_ff        <= p_in;
      pf_ff       <= pf_in;
      err_ff      <= err_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_pres_ff <= rsp_pres_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_pres_ff, rsp_temp_ff};
   assign rsp_tuser  = rsp_err_ff;
endmodule
`default_nettype wire

### rtl/core/barometric_sensor_compensation.sv
// Barometric pressure and temperature compensation, top level.
// Channels: req_ carries one word of raw temperature and raw pressure; rsp_ returns
// one word of compensated temperature (0.1 degC) and pressure (Pa), with tuser set
// when a divisor was zero (both result fields are then zero).
// Calibration coefficients and oversampling are loaded through the csr_ write port, which
// the user must do only while the block is idle; the block does not enforce it.
// They reset to zero. The back end handles one word at a time; its work on a word is
// set by two passes through the shared bit-serial divider and five passes through the
// shared 16-bit-digit multiplier.
// A request queue of QUEUE_DEPTH words keeps req_tready high while the back end works
// until the queue is full, and the result register lets the back end finish the next
// word while the receiver stalls; a word waits in the back end only when that
// register is still full. Reset (synchronous, active high) empties the queue, drops any
// word in flight and clears rsp_tvalid.
// Depends on bsc_pkg, bsc_front, bsc_mul, bsc_div, bsc_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module barometric_sensor_compensation #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // raw_temperature[15:0], raw_pressure[34:16], zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // temperature_tenths[15:0], pressure_pa[35:16], zero
   output logic             rsp_tuser,   // divide_error
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [63:0] csr_wdata
);
   bsc_pkg::cal_type      cal_ff, cal_in;
   logic                  q_valid, q_pop;
   bsc_pkg::item_type     q_item;
   bsc_pkg::mul_req_type  mul_req;
   bsc_pkg::mul_rsp_type  mul_rsp;
   bsc_pkg::div_req_type  div_req;
   bsc_pkg::div_rsp_type  div_rsp;

   // Calibration registers.
   always_comb begin
      cal_in = cal_ff;
      if (csr_we) begin
         case (bsc_pkg::csr_index_type'(csr_addr))
            bsc_pkg::CSR_AC1_AC4: begin
               cal_in.ac1 = csr_wdata[63:48];
               cal_in.ac2 = csr_wdata[47:32];
               cal_in.ac3 = csr_wdata[31:16];
               cal_in.ac4 = csr_wdata[15:0];
            end
            bsc_pkg::CSR_AC5_B2: begin
               cal_in.ac5 = csr_wdata[63:48];
               cal_in.ac6 = csr_wdata[47:32];
               cal_in.b1  = csr_wdata[31:16];
               cal_in.b2  = csr_wdata[15:0];
            end
            bsc_pkg::CSR_MC_MD: begin
               cal_in.mc = csr_wdata[31:16];
               cal_in.md = csr_wdata[15:0];
            end
            bsc_pkg::CSR_OSS: begin
               cal_in.oss = csr_wdata[1:0];
            end
            default: begin
               cal_in = cal_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   bsc_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   bsc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   bsc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   bsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cal        (cal_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .mul_req    (mul_req),
      .mul_rsp    (mul_rsp),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // The back end only takes a word that the queue holds.
   `ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && !q_valid)
   // Multiplier and divider are used one after the other, never together.
   `ASSERT_NEVER(a_units_overlap, clock, reset, mul_rsp.busy && div_rsp.busy)
   // A divide error returns zero in both result fields.
   `ASSERT_ALWAYS(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata[35:0] == 36'd0)
endmodule
`default_nettype wire
